[design/salrc_pkg.sv]
// Package for the set-associative read cache: geometry constants, field
// widths, status codes and the controller state type. No dependencies.
`default_nettype none
package salrc_pkg;
   localparam int NumSets   = 4;
   localparam int NumWays   = 2;
   localparam int MemWords  = 128;
   localparam int SetW      = (NumSets > 1) ? $clog2(NumSets) : 1;
   localparam int WayW      = (NumWays > 1) ? $clog2(NumWays) : 1;
   localparam int MemW      = $clog2(MemWords);
   localparam int TagW      = 9 - SetW;
   localparam int LineW     = 1 + TagW + 32 + 64;
   localparam int SetMemW   = NumWays * LineW;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_CROSS = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        mode;
      logic [11:0] byte_address;
      logic [1:0]  access_size;
      logic [6:0]  load_index;
      logic [31:0] load_word;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        was_hit;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [TagW-1:0]   tag;
      logic [31:0]       stamp;
      logic [63:0]       bytes;
   } line_type;

   function automatic logic [31:0] pick_bytes(input logic [63:0] line,
                                              input logic [2:0] offset,
                                              input logic [1:0] size);
      logic [63:0] sh;
      logic [31:0] v;
      sh = line >> {offset, 3'b000};
      unique case (size)
         2'd0:    v = {24'd0, sh[7:0]};
         2'd1:    v = {16'd0, sh[15:0]};
         default: v = sh[31:0];
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

[design/salrc_if.sv]
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface salrc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/set_assoc_lru_read_cache.sv]
// Top level of the set-associative read cache with its backing memory.
// Depends on salrc_pkg and salrc_if.
//
//  channel   dir  payload
//  req       in   mode, byte_address, access_size, load_index, load_word
//  rsp       out  read_value, was_hit, status
//
// An access goes from accept through a set read to a hit or reject response,
// plus a fill step on a miss using the backing memory words read alongside
// the tag compare. Word writes go from accept straight to the response. Reset
// is synchronous and sweeps valid bits clear set by set, holding off req.
// A stalled rsp word holds; the next word is taken once it drains.
`default_nettype none
module set_assoc_lru_read_cache
   import salrc_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   salrc_if.sink    req,
   salrc_if.source  rsp
);
   logic [SetMemW-1:0] set_mem [NumSets];
   logic [31:0]        back_mem [MemWords];

   state_type          state_ff, state_in;
   logic [SetW:0]      clr_ff, clr_in;
   logic [11:0]        addr_ff;
   logic [1:0]         size_ff;
   logic [31:0]        stamp_ff, stamp_in;
   logic [SetMemW-1:0] set_rd_ff;
   logic [63:0]        back_rd_ff;
   logic [WayW-1:0]    way_ff, way_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   req_type            rq;

   logic               clearing;
   logic [8:0]         block;
   logic [SetW-1:0]    set_idx;
   logic [TagW-1:0]    tag;
   logic [2:0]         offset;
   logic [3:0]         span;
   logic               bad_range, bad_cross;
   logic               hit;
   logic [WayW-1:0]    hit_way, vict_way;
   logic               set_we;
   logic [SetW-1:0]    set_wa;
   logic [SetMemW-1:0] set_wd;
   line_type           cur_line, new_line;

   assign clearing = !clr_ff[SetW];
   assign rq       = req.payload;
   assign req.ready = !clearing && state_ff == ST_IDLE && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   assign block   = addr_ff[11:3];
   assign offset  = addr_ff[2:0];
   assign set_idx = block[SetW-1:0];
   assign tag     = block[8:SetW];
   assign span    = {1'b0, offset} + ((size_ff == 2'd0) ? 4'd1 :
                                      (size_ff == 2'd1) ? 4'd2 : 4'd4);
   assign bad_range = ({1'b0, block, 1'b1}) >= 11'(MemWords);
   assign bad_cross = span > 4'd8;

   always_comb begin
      line_type l;
      logic     got;
      got = 1'b0;
      hit_way = '0;
      vict_way = '0;
      for (int w = NumWays - 1; w >= 0; w--) begin
         l = set_rd_ff[w*LineW +: LineW];
         if (l.valid && l.tag == tag) begin
            got = 1'b1;
            hit_way = WayW'(w);
         end
      end
      hit = got;
      got = 1'b0;
      for (int w = 0; w < NumWays; w++) begin
         l = set_rd_ff[w*LineW +: LineW];
         if (!l.valid && !got) begin
            got = 1'b1;
            vict_way = WayW'(w);
         end
      end
      if (!got) begin
         l = set_rd_ff[0 +: LineW];
         for (int w = 1; w < NumWays; w++) begin
            if (set_rd_ff[w*LineW + 64 +: 32] < set_rd_ff[int'(vict_way)*LineW + 64 +: 32])
               vict_way = WayW'(w);
         end
      end
   end

   assign cur_line = set_rd_ff[int'(way_ff)*LineW +: LineW];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req.valid && req.ready) state_in = rq.mode ? ST_DONE : ST_LOOK;
         ST_LOOK: state_in = (bad_range || bad_cross || hit) ? ST_DONE : ST_FILL;
         ST_FILL: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      clr_in       = clearing ? clr_ff + 1'b1 : clr_ff;
      stamp_in     = stamp_ff;
      way_in       = way_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      set_we       = clearing;
      set_wa       = clearing ? clr_ff[SetW-1:0] : set_idx;
      set_wd       = set_rd_ff;
      new_line     = cur_line;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready && rq.mode) begin
               rsp_in = '{read_value: '0, was_hit: 1'b0,
                          status: (32'(rq.load_index) < 32'(MemWords)) ? STAT_OK : STAT_RANGE};
            end
         end
         ST_LOOK: begin
            way_in = hit ? hit_way : vict_way;
            if (bad_range) begin
               rsp_in = '{read_value: '0, was_hit: 1'b0, status: STAT_RANGE};
            end else if (bad_cross) begin
               rsp_in = '{read_value: '0, was_hit: 1'b0, status: STAT_CROSS};
            end else if (hit) begin
               new_line = set_rd_ff[int'(hit_way)*LineW +: LineW];
               new_line.stamp = stamp_ff;
               set_we = 1'b1;
               set_wd[int'(hit_way)*LineW +: LineW] = new_line;
               stamp_in = stamp_ff + 32'd1;
               rsp_in = '{read_value: pick_bytes(new_line.bytes, offset, size_ff),
                          was_hit: 1'b1, status: STAT_OK};
            end
         end
         ST_FILL: begin
            new_line = '{valid: 1'b1, tag: tag, stamp: stamp_ff, bytes: back_rd_ff};
            set_we = 1'b1;
            set_wd[int'(way_ff)*LineW +: LineW] = new_line;
            stamp_in = stamp_ff + 32'd1;
            rsp_in = '{read_value: pick_bytes(back_rd_ff, offset, size_ff),
                       was_hit: 1'b0, status: STAT_OK};
         end
         ST_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
      if (clearing) set_wd = '0;
   end

   always_ff @(posedge clock) begin
      if (set_we) set_mem[set_wa] <= set_wd;
      set_rd_ff <= set_mem[req.valid && req.ready ? rq.byte_address[3 +: SetW] : set_idx];
      if (req.valid && req.ready && rq.mode && 32'(rq.load_index) < 32'(MemWords))
         back_mem[rq.load_index[MemW-1:0]] <= rq.load_word;
      back_rd_ff[31:0]  <= back_mem[{block[MemW-2:0], 1'b0}];
      back_rd_ff[63:32] <= back_mem[{block[MemW-2:0], 1'b1}];
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         addr_ff <= rq.byte_address;
         size_ff <= rq.access_size;
      end
      way_ff <= way_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         clr_ff       <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

[bench/tb.sv]
// Testbench for set_assoc_lru_read_cache: random and directed words with idling on both
// sides, checked against a behavioural LRU cache with its backing memory.
// Depends on salrc_pkg, salrc_if and the block itself.
`timescale 1ns / 1ps
module tb;
   import salrc_pkg::*;

   typedef struct {
      req_type word;
      bit      hold_off;
   } pending_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   salrc_if #(.payload_type(req_type)) req_ch ();
   salrc_if #(.payload_type(rsp_type)) rsp_ch ();

   set_assoc_lru_read_cache i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch.sink),
      .rsp  (rsp_ch.source)
   );

   always #10 clock = ~clock;

   pending_type pending_q[$];
   rsp_type     expected_q[$];

   bit          line_ok[NumSets*NumWays];
   logic [6:0]  line_tag[NumSets*NumWays];
   logic [31:0] line_stamp[NumSets*NumWays];
   logic [63:0] line_data[NumSets*NumWays];
   logic [31:0] mem_word[MemWords];
   bit          mem_set[MemWords];
   logic [31:0] stamp_now;

   int unsigned sent_count;
   int unsigned got_count;
   int unsigned mismatches;
   int unsigned req_gap;
   int unsigned rsp_gap;
   bit          req_taken;

   function automatic int find_way(logic [11:0] addr);
      int set_base;
      set_base = addr[4:3] * NumWays;
      for (int w = 0; w < NumWays; w++)
         if (line_ok[set_base+w] && line_tag[set_base+w] == addr[11:5]) return w;
      return -1;
   endfunction

   function automatic rsp_type cache_read(req_type r);
      rsp_type     o;
      int          set_base, way, count;
      logic [8:0]  block;
      logic [63:0] sh;
      o = '{read_value: 32'd0, was_hit: 1'b0, status: STAT_OK};
      if (r.mode) begin
         mem_word[r.load_index] = r.load_word;
         mem_set[r.load_index]  = 1'b1;
         return o;
      end
      block = r.byte_address[11:3];
      count = (r.access_size == 2'd0) ? 1 : (r.access_size == 2'd1) ? 2 : 4;
      if (block * 2 + 1 >= MemWords) begin
         o.status = STAT_RANGE;
         return o;
      end
      if (r.byte_address[2:0] + count > 8) begin
         o.status = STAT_CROSS;
         return o;
      end
      set_base = block[1:0] * NumWays;
      way = find_way(r.byte_address);
      if (way >= 0) begin
         o.was_hit = 1'b1;
      end else begin
         way = 0;
         for (int w = NumWays - 1; w >= 0; w--)
            if (!line_ok[set_base+w]) way = w;
         if (line_ok[set_base+way])
            for (int w = 1; w < NumWays; w++)
               if (line_stamp[set_base+w] < line_stamp[set_base+way]) way = w;
         line_ok[set_base+way]   = 1'b1;
         line_tag[set_base+way]  = block[8:2];
         line_data[set_base+way] = {mem_word[block*2+1], mem_word[block*2]};
      end
      line_stamp[set_base+way] = stamp_now;
      stamp_now = stamp_now + 32'd1;
      sh = line_data[set_base+way] >> (8 * r.byte_address[2:0]);
      o.read_value = (count == 1) ? {24'd0, sh[7:0]} :
                     (count == 2) ? {16'd0, sh[15:0]} : sh[31:0];
      return o;
   endfunction

   task automatic push_word(req_type r, bit hold_off = 1'b0);
      pending_type p;
      p.word = r;
      p.hold_off = hold_off;
      pending_q.push_back(p);
      expected_q.push_back(cache_read(r));
   endtask

   task automatic push_load(int idx, logic [31:0] val, bit hold_off = 1'b0);
      req_type r;
      r = '0;
      r.mode = 1'b1;
      r.load_index = 7'(idx);
      r.load_word = val;
      r.byte_address = 12'($urandom);
      r.access_size = 2'($urandom);
      push_word(r, hold_off);
   endtask

   task automatic push_access(logic [11:0] addr, logic [1:0] size, bit hold_off = 1'b0);
      req_type r;
      r = '0;
      r.byte_address = addr;
      r.access_size = size;
      r.load_index = 7'($urandom);
      r.load_word = $urandom;
      push_word(r, hold_off);
   endtask

   always @(posedge clock) begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) sent_count <= sent_count + 1;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_count <= got_count + 1;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %p", rsp_ch.payload);
         end else begin
            if (rsp_ch.payload !== expected_q[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, actual %p", expected_q[0], rsp_ch.payload);
            end
            void'(expected_q.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_ch.valid && !req_taken)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_q.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (pending_q[0].hold_off && got_count != sent_count) begin
               req_ch.valid <= 1'b0;
            end else if (pending_q.size() > 150 && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 3);
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.payload <= pending_q[0].word;
               req_ch.valid <= 1'b1;
               void'(pending_q.pop_front());
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (pending_q.size() > 150 && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [11:0] addr;
      logic [1:0]  size;
      int          block, way;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < NumSets * NumWays; i++) begin
         line_ok[i] = 1'b0;
         line_stamp[i] = 32'd0;
      end
      stamp_now = 32'd0;

      push_load(0, 32'h0000_0000);
      push_load(1, 32'hffff_ffff);
      push_load(8, 32'h8765_4321);
      push_load(9, 32'hdead_beef);
      push_load(16, 32'h0123_4567);
      push_load(17, 32'h89ab_cdef);
      push_access(12'd0, 2'd0);
      push_access(12'd7, 2'd0);
      push_access(12'd6, 2'd1);
      push_access(12'd7, 2'd1);
      push_access(12'd4, 2'd2);
      push_access(12'd5, 2'd2);
      push_access(12'd0, 2'd3);
      push_access(12'd32, 2'd2);
      push_access(12'd64, 2'd2);
      push_access(12'd36, 2'd1);
      push_access(12'd4095, 2'd0);
      push_access(12'd512, 2'd2);
      push_load(0, 32'h5555_aaaa);
      push_access(12'd2, 2'd1);
      push_access(12'd68, 2'd2);

      for (int n = 0; n < 1900; n++) begin
         if ($urandom_range(0, 9) < 3) begin
            push_load(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) :
                      $urandom_range(0, 31), $urandom, n == 1000);
         end else begin
            case ($urandom_range(0, 9))
               0:       addr = 12'($urandom_range(512, 4095));
               1:       addr = 12'($urandom_range(0, 511));
               default: addr = 12'($urandom_range(0, 127));
            endcase
            size = 2'($urandom);
            block = addr[11:3];
            way = find_way(addr);
            if (block * 2 + 1 < MemWords && way < 0 &&
                (!mem_set[block*2] || !mem_set[block*2+1]))
               push_load(mem_set[block*2] ? block * 2 + 1 : block * 2, $urandom, n == 1000);
            else
               push_access(addr, size, n == 1000);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0);
      wait (expected_q.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
